@@ rtl/transform_accumulate_and_apply_unit_macros.svh @@
// Assertion macros for the transform accumulate and apply unit.
// Depends on a clock named clock and a synchronous reset named reset in the including scope.
`ifndef TRANSFORM_ACCUMULATE_AND_APPLY_UNIT_MACROS_SVH
`define TRANSFORM_ACCUMULATE_AND_APPLY_UNIT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define TAAU_ASSERT_NOW(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("taau assertion failed");

// condition in this cycle implies consequence in the next cycle
`define TAAU_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("taau assertion failed");

`endif

@@ rtl/taau_pkg.sv @@
// Shared types, constants and the scale-and-saturate function of the transform unit.
// No dependencies.
package taau_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int OPB_WIDTH   = VALUE_WIDTH + 1;
   localparam int PROD_WIDTH  = VALUE_WIDTH + OPB_WIDTH;
   localparam int SUM_WIDTH   = 2 * VALUE_WIDTH + 4;
   localparam int MAT_ROWS    = 3;
   localparam int MAT_COLS    = 4;

   localparam logic [2:0] ACT_IDENTITY  = 3'd0;
   localparam logic [2:0] ACT_WRITE     = 3'd1;
   localparam logic [2:0] ACT_TRANSLATE = 3'd2;
   localparam logic [2:0] ACT_ROTATE    = 3'd3;
   localparam logic [2:0] ACT_XFORM_PT  = 3'd4;
   localparam logic [2:0] ACT_ROTATE_PT = 3'd5;
   localparam logic [2:0] ACT_READ      = 3'd6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [1:0] COL_TRANS = 2'd3;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] ONE_VALUE =
      (FRAC_BITS >= VALUE_WIDTH - 1) ? VALUE_MAX : VALUE_WIDTH'(64'd1 << FRAC_BITS);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] axis;
      value_type  val_a;
      value_type  val_b;
      value_type  val_c;
   } req_item_type;

   // floor shift by FRAC_BITS, then clamp to the value range
   function automatic value_type scale_sat(input logic signed [SUM_WIDTH-1:0] s);
      logic signed [SUM_WIDTH-1:0] sh;
      logic [SUM_WIDTH-VALUE_WIDTH:0] top;
      value_type res;
      sh  = s >>> FRAC_BITS;
      top = sh[SUM_WIDTH-1:VALUE_WIDTH-1];
      if ((top == '0) || (top == '1)) begin
         res = sh[VALUE_WIDTH-1:0];
      end else if (sh[SUM_WIDTH-1]) begin
         res = VALUE_MIN;
      end else begin
         res = VALUE_MAX;
      end
      return res;
   endfunction

endpackage

@@ rtl/taau_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on taau_pkg.
interface taau_req_if import taau_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [1:0] row;
   logic [1:0] col;
   logic [1:0] axis;
   value_type  val_a;
   value_type  val_b;
   value_type  val_c;

   modport source (output valid, action, row, col, axis, val_a, val_b, val_c, input ready);
   modport sink (input valid, action, row, col, axis, val_a, val_b, val_c, output ready);
endinterface

interface taau_rsp_if import taau_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type out_x;
   value_type out_y;
   value_type out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

@@ rtl/transform_accumulate_and_apply_unit.sv @@
// Top level of the homogeneous transform accumulate and apply unit.
// Depends on taau_pkg, taau_if and transform_accumulate_and_apply_unit_macros.svh.
//
// The unit holds the top three rows of a Q16.16 homogeneous transform and
// takes one command item per cycle: identity, element write, translation or
// rotation post-multiply, point transform, point rotation and element read.
// An accepted item is held in the input register, where three row lanes
// of four multipliers each, with adders and two saturating scalers per lane,
// update the matrix and load the output register; point and read items show
// their result in the output register. Throughput is one item per cycle while
// no stall holds the input, set by the matrix-to-matrix multiply-accumulate path.
// Outside reset, the input side stalls only while a result waits in the output
// register and the item in the input register also produces a result.
`include "transform_accumulate_and_apply_unit_macros.svh"

module transform_accumulate_and_apply_unit import taau_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   taau_req_if.sink   req_ch,
   taau_rsp_if.source rsp_ch
);

   typedef value_type mat_type [MAT_ROWS][MAT_COLS];

   localparam mat_type IDENTITY = '{
      '{ONE_VALUE, '0, '0, '0},
      '{'0, ONE_VALUE, '0, '0},
      '{'0, '0, ONE_VALUE, '0}
   };

   req_item_type in_ff;
   logic         in_valid_ff;
   mat_type      mat_ff, mat_in;
   logic         out_valid_ff, out_valid_in;
   value_type    out_x_ff, out_y_ff, out_z_ff;
   value_type    out_x_in, out_y_in, out_z_in;

   logic needs_rsp;
   logic advance;
   logic req_ready;

   value_type sat0 [MAT_ROWS];
   value_type sat1 [MAT_ROWS];

   assign needs_rsp = (in_ff.action == ACT_XFORM_PT) || (in_ff.action == ACT_ROTATE_PT) ||
                      (in_ff.action == ACT_READ);
   assign advance   = in_valid_ff && (!needs_rsp || !out_valid_ff || rsp_ch.ready);
   assign req_ready = !in_valid_ff || advance;

   // take no item while in reset
   assign req_ch.ready = req_ready && !reset;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.out_z = out_z_ff;

   // row lanes: four products each, two scaled sums
   always_comb begin
      logic                          pt;
      logic signed [OPB_WIDTH-1:0]   s_ext, c_ext, ns_ext, s1, s2;
      value_type                     u, v, h;
      value_type                     ma [4];
      logic signed [OPB_WIDTH-1:0]   mb [4];
      logic signed [PROD_WIDTH-1:0]  prod [4];
      logic signed [SUM_WIDTH-1:0]   sum0, sum1;
      pt     = (in_ff.action != ACT_ROTATE);
      s_ext  = OPB_WIDTH'(in_ff.val_a);
      c_ext  = OPB_WIDTH'(in_ff.val_b);
      ns_ext = -s_ext;
      s1     = (in_ff.axis == AXIS_Y) ? ns_ext : s_ext;
      s2     = (in_ff.axis == AXIS_Y) ? s_ext : ns_ext;
      for (int r = 0; r < MAT_ROWS; r++) begin
         unique case (in_ff.axis)
            AXIS_X: begin
               u = mat_ff[r][1];
               v = mat_ff[r][2];
            end
            AXIS_Y: begin
               u = mat_ff[r][0];
               v = mat_ff[r][2];
            end
            default: begin
               u = mat_ff[r][0];
               v = mat_ff[r][1];
            end
         endcase
         h = ((in_ff.action == ACT_TRANSLATE) || (in_ff.action == ACT_XFORM_PT)) ?
             mat_ff[r][3] : '0;
         ma[0] = pt ? mat_ff[r][0] : u;
         ma[1] = pt ? mat_ff[r][1] : v;
         ma[2] = pt ? mat_ff[r][2] : u;
         ma[3] = v;
         mb[0] = pt ? OPB_WIDTH'(in_ff.val_a) : c_ext;
         mb[1] = pt ? OPB_WIDTH'(in_ff.val_b) : s1;
         mb[2] = pt ? OPB_WIDTH'(in_ff.val_c) : s2;
         mb[3] = c_ext;
         for (int k = 0; k < 4; k++) begin
            prod[k] = ma[k] * mb[k];
         end
         sum0 = SUM_WIDTH'(prod[0]) + SUM_WIDTH'(prod[1]);
         if (pt) begin
            sum0 = sum0 + SUM_WIDTH'(prod[2]) + (SUM_WIDTH'(h) <<< FRAC_BITS);
         end
         sum1 = SUM_WIDTH'(prod[2]) + SUM_WIDTH'(prod[3]);
         sat0[r] = scale_sat(sum0);
         sat1[r] = scale_sat(sum1);
      end
   end

   // matrix update and result selection
   always_comb begin
      mat_in   = mat_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      if (advance) begin
         unique case (in_ff.action)
            ACT_IDENTITY: begin
               mat_in = IDENTITY;
            end
            ACT_WRITE: begin
               if (in_ff.row < 2'(MAT_ROWS)) begin
                  mat_in[in_ff.row][in_ff.col] = in_ff.val_a;
               end
            end
            ACT_TRANSLATE: begin
               for (int r = 0; r < MAT_ROWS; r++) begin
                  mat_in[r][3] = sat0[r];
               end
            end
            ACT_ROTATE: begin
               for (int r = 0; r < MAT_ROWS; r++) begin
                  unique case (in_ff.axis)
                     AXIS_X: begin
                        mat_in[r][1] = sat0[r];
                        mat_in[r][2] = sat1[r];
                     end
                     AXIS_Y: begin
                        mat_in[r][0] = sat0[r];
                        mat_in[r][2] = sat1[r];
                     end
                     AXIS_Z: begin
                        mat_in[r][0] = sat0[r];
                        mat_in[r][1] = sat1[r];
                     end
                     default: begin
                        // no such axis: hold the matrix
                     end
                  endcase
               end
            end
            ACT_XFORM_PT, ACT_ROTATE_PT: begin
               out_x_in = sat0[0];
               out_y_in = sat0[1];
               out_z_in = sat0[2];
            end
            ACT_READ: begin
               if (in_ff.row < 2'(MAT_ROWS)) begin
                  out_x_in = mat_ff[in_ff.row][in_ff.col];
               end else begin
                  out_x_in = (in_ff.col == COL_TRANS) ? ONE_VALUE : '0;
               end
               out_y_in = '0;
               out_z_in = '0;
            end
            default: begin
               // undefined command: drop the item
            end
         endcase
      end
   end

   assign out_valid_in = (advance && needs_rsp) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mat_ff       <= IDENTITY;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
         mat_ff       <= mat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ff.action <= req_ch.action;
         in_ff.row    <= req_ch.row;
         in_ff.col    <= req_ch.col;
         in_ff.axis   <= req_ch.axis;
         in_ff.val_a  <= req_ch.val_a;
         in_ff.val_b  <= req_ch.val_b;
         in_ff.val_c  <= req_ch.val_c;
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
   end

   `TAAU_ASSERT_NOW(a_ready_when_out_free, !out_valid_ff, req_ready)
   `TAAU_ASSERT_NEXT(a_hold_stalled_item, in_valid_ff && !advance, in_valid_ff && $stable(in_ff))
   `TAAU_ASSERT_NEXT(a_result_loaded, advance && needs_rsp, out_valid_ff)
   `TAAU_ASSERT_NEXT(a_identity_loaded, advance && (in_ff.action == ACT_IDENTITY),
      (mat_ff[1][1] == ONE_VALUE) && (mat_ff[0][3] == '0))

endmodule
